// ===== sv/tpft_pkg.sv =====
// ----------------------------------------------------------------------------
// TLB and page frame tracker package
// Shared word types, table commands and code constants.
// ----------------------------------------------------------------------------
package tpft_pkg;

  localparam int PID_W  = 4;
  localparam int PAGE_W = 28;
  localparam int KEY_W  = PID_W + PAGE_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 11;

  // Item operation codes.
  localparam logic [1:0] OP_ACCESS = 2'd0;
  localparam logic [1:0] OP_SLICE  = 2'd1;
  localparam logic [1:0] OP_END    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TLB_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TLB_PER_PROC = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EVICT_POLICY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PHYS_PAGES  = 3'd4;

  typedef struct packed {
    logic [1:0]        op;
    logic [PID_W-1:0]  process_id;
    logic [31:0]       address;
  } in_word_t;

  typedef struct packed {
    logic              tlb_hit;
    logic              page_fault;
    logic              evicted;
    logic [PID_W-1:0]  evicted_process;
    logic [PAGE_W-1:0] evicted_page;
    logic [10:0]       freed_pages;
  } out_word_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_TOUCH,
    ACT_REMOVE,
    ACT_FLUSH,
    ACT_SCAN_INS,
    ACT_SCAN_PURGE
  } tbl_act_t;

  // Broadcast to every cell of a table. qsel picks the lookup: by key or by rank.
  typedef struct packed {
    tbl_act_t          act;
    logic              qsel;
    logic              start;
    logic [KEY_W-1:0]  key;
    logic [PID_W-1:0]  pid;
  } tbl_cmd_t;

  typedef struct packed {
    logic              q_hit;
    logic [KEY_W-1:0]  q_key;
    logic              scan_done;
    logic              act_any;
  } tbl_stat_t;

endpackage

// ===== sv/tpft_cell.sv =====
// ----------------------------------------------------------------------------
// TLB and page frame tracker cell
// One table entry: valid, key and recency rank, with a scan token passed on.
// ----------------------------------------------------------------------------
module tpft_cell import tpft_pkg::*; #(
  parameter int RW = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tbl_cmd_t         cmd,
  input  logic [RW-1:0]    arg,
  input  logic             tok_in,
  input  logic             act_any,
  input  logic [RW-1:0]    act_rank,
  output logic             tok_out,
  output logic             tok_now,
  output logic             act,
  output logic             q_match,
  output logic [RW-1:0]    rank_o,
  output logic [KEY_W-1:0] key_o
);

  logic             valid_r, valid_nxt;
  logic             tok_r, tok_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [RW-1:0]    rank_r, rank_nxt;
  logic             is_ins, is_purge, key_hit;

  assign is_ins   = (cmd.act == ACT_SCAN_INS);
  assign is_purge = (cmd.act == ACT_SCAN_PURGE);
  assign key_hit  = valid_r && (key_r == cmd.key);

  assign act = tok_r && (is_ins ? !valid_r
                        : (is_purge && valid_r && (key_r[KEY_W-1 -: PID_W] == cmd.pid)));
  // An insert stops at the first free cell; a purge runs the whole row.
  assign tok_out = tok_r && !(is_ins && act);
  assign tok_now = tok_r;
  assign tok_nxt = (is_ins || is_purge) ? tok_in : 1'b0;

  assign q_match = cmd.qsel ? (valid_r && (rank_r == arg)) : key_hit;
  assign rank_o  = rank_r;
  assign key_o   = key_r;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    rank_nxt  = rank_r;
    unique case (cmd.act)
      ACT_TOUCH: begin
        if (key_hit) rank_nxt = '0;
        else if (valid_r && rank_r < arg) rank_nxt = rank_r + RW'(1);
      end
      ACT_REMOVE: begin
        if (key_hit) valid_nxt = 1'b0;
        else if (valid_r && rank_r > arg) rank_nxt = rank_r - RW'(1);
      end
      ACT_FLUSH: valid_nxt = 1'b0;
      ACT_SCAN_INS: begin
        if (act) begin
          valid_nxt = 1'b1;
          key_nxt   = cmd.key;
          rank_nxt  = '0;
        end else if (valid_r && act_any) begin
          rank_nxt = rank_r + RW'(1);
        end
      end
      ACT_SCAN_PURGE: begin
        if (act) valid_nxt = 1'b0;
        else if (valid_r && act_any && rank_r > act_rank) rank_nxt = rank_r - RW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    rank_r <= rank_nxt;
  end

endmodule

// ===== sv/tpft_table.sv =====
// ----------------------------------------------------------------------------
// TLB and page frame tracker table
// A row of cells with a shared lookup bus, a scan token chain and a fill count.
// ----------------------------------------------------------------------------
module tpft_table import tpft_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int RW    = 8,
  parameter int CW    = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tbl_cmd_t      cmd,
  input  logic [RW-1:0] arg,
  output tbl_stat_t     stat,
  output logic [RW-1:0] q_rank,
  output logic [CW-1:0] count
);

  logic [DEPTH-1:0]    tok_in, tok_out, tok_now, act, q_match;
  logic [RW-1:0]       rank [DEPTH];
  logic [KEY_W-1:0]    key  [DEPTH];
  logic                act_any, q_hit;
  logic [RW-1:0]       act_rank, q_rank_or;
  logic [KEY_W-1:0]    q_key_or;
  logic [CW-1:0]       count_r, count_nxt;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign tok_in[i] = cmd.start;
    end else begin : g_link
      assign tok_in[i] = tok_out[i-1];
    end
    tpft_cell #(.RW(RW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .arg      (arg),
      .tok_in   (tok_in[i]),
      .act_any  (act_any),
      .act_rank (act_rank),
      .tok_out  (tok_out[i]),
      .tok_now  (tok_now[i]),
      .act      (act[i]),
      .q_match  (q_match[i]),
      .rank_o   (rank[i]),
      .key_o    (key[i])
    );
  end

  // At most one cell matches a lookup and at most one cell acts in a cycle,
  // so a plain OR bus returns its fields.
  always_comb begin
    act_any   = 1'b0;
    act_rank  = '0;
    q_hit     = 1'b0;
    q_rank_or = '0;
    q_key_or  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      act_any   = act_any | act[i];
      act_rank  = act_rank | (act[i] ? rank[i] : '0);
      q_hit     = q_hit | q_match[i];
      q_rank_or = q_rank_or | (q_match[i] ? rank[i] : '0);
      q_key_or  = q_key_or | (q_match[i] ? key[i] : '0);
    end
  end

  always_comb begin
    count_nxt = count_r;
    unique case (cmd.act)
      ACT_SCAN_INS:   if (act_any) count_nxt = count_r + CW'(1);
      ACT_SCAN_PURGE: if (act_any && count_r != '0) count_nxt = count_r - CW'(1);
      ACT_REMOVE:     if (q_hit && !cmd.qsel && count_r != '0) count_nxt = count_r - CW'(1);
      ACT_FLUSH:      count_nxt = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else        count_r <= count_nxt;
  end

  assign count          = count_r;
  assign q_rank         = q_rank_or;
  assign stat.q_hit     = q_hit;
  assign stat.q_key     = q_key_or;
  assign stat.act_any   = act_any;
  assign stat.scan_done = ((cmd.act == ACT_SCAN_INS) && act_any) ||
                          ((cmd.act == ACT_SCAN_PURGE) && tok_now[DEPTH-1]);

  always_ff @(posedge clk) begin
    if (rst_n) begin
      assert (count_r <= CW'(DEPTH))
        else $error("table count above depth");
    end
  end

  a_one_act: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(act)) else $error("more than one cell acted");
  a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(q_match)) else $error("lookup matched more than one cell");
  a_tok: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_now)) else $error("more than one scan token");

endmodule

// ===== sv/tlb_and_page_frame_tracker_top.sv =====
// ----------------------------------------------------------------------------
// TLB and page frame tracker top level
// Process-tagged LRU TLB in front of a FIFO or LRU store of resident pages.
// ----------------------------------------------------------------------------
// One item at a time: an item is taken when start is high and busy is low,
// and its single result word shows on out_word for one cycle with out_valid,
// which the receiver must take. A TLB hit finds and touches the TLB entry and,
// with the LRU policy, the page entry too. A miss adds a token scan down the
// TLB cell row and, on a page fault, one down the page cell row, plus a drop
// step for each entry removed on the way; a process end scans both rows in
// full. Those scans set the rate, as no new item is taken while busy is high.
// Every entry carries its own valid bit, so the block is ready right after
// reset. The configuration port is always ready.
module tlb_and_page_frame_tracker_top import tpft_pkg::*; #(
  parameter int TLB_DEPTH     = 256,
  parameter int PAGE_DEPTH    = 1024,
  parameter int MAX_PROCESSES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_word_t              in_word,
  output logic                  out_valid,
  output out_word_t             out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int TRW = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
  localparam int PRW = (PAGE_DEPTH > 1) ? $clog2(PAGE_DEPTH) : 1;
  localparam int TCW = $clog2(TLB_DEPTH + 1);
  localparam int PCW = $clog2(PAGE_DEPTH + 1);
  localparam int PPW = (PCW > 11) ? PCW : 11;

  typedef enum logic [4:0] {
    ST_IDLE, ST_T_FIND, ST_T_TOUCH, ST_P_HFIND, ST_P_TOUCH,
    ST_T_TRIM, ST_T_DROP, ST_T_INS_GO, ST_T_INS,
    ST_P_FIND, ST_P_TRIM, ST_P_DROP, ST_V_FIND, ST_V_DROP,
    ST_P_INS_GO, ST_P_INS, ST_FLUSH,
    ST_T_PURGE_GO, ST_T_PURGE, ST_P_PURGE_GO, ST_P_PURGE, ST_DONE
  } state_t;

  state_t            state_r;
  logic [4:0]        page_shift_r;
  logic [8:0]        tlb_limit_r;
  logic              tlb_per_proc_r;
  logic              evict_policy_r;
  logic [10:0]       phys_pages_r;
  logic [KEY_W-1:0]  key_r, vkey_r;
  logic [TRW-1:0]    t_rank_r;
  logic [PRW-1:0]    p_rank_r;
  out_word_t         res_r;
  logic              out_valid_r;

  tbl_cmd_t          t_cmd, p_cmd;
  logic [TRW-1:0]    t_arg, t_q_rank;
  logic [PRW-1:0]    p_arg, p_q_rank;
  tbl_stat_t         t_stat, p_stat;
  logic [TCW-1:0]    t_count;
  logic [PCW-1:0]    p_count;

  logic [4:0]        sh;
  logic [8:0]        tl;
  logic [PPW-1:0]    pp;
  logic [31:0]       shifted;
  logic              accept;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = res_r;

  assign sh = (page_shift_r < 5'd4) ? 5'd4 : ((page_shift_r > 5'd16) ? 5'd16 : page_shift_r);
  assign tl = (tlb_limit_r < 9'd8) ? 9'd8
            : ((tlb_limit_r > 9'(TLB_DEPTH)) ? 9'(TLB_DEPTH) : tlb_limit_r);
  assign pp = (phys_pages_r == 11'd0) ? PPW'(1)
            : ((PPW'(phys_pages_r) > PPW'(PAGE_DEPTH)) ? PPW'(PAGE_DEPTH) : PPW'(phys_pages_r));
  assign shifted = in_word.address >> sh;

  tpft_table #(.DEPTH(TLB_DEPTH), .RW(TRW), .CW(TCW)) u_tlb (
    .clk (clk), .rst_n (rst_n), .cmd (t_cmd), .arg (t_arg),
    .stat (t_stat), .q_rank (t_q_rank), .count (t_count)
  );

  tpft_table #(.DEPTH(PAGE_DEPTH), .RW(PRW), .CW(PCW)) u_page (
    .clk (clk), .rst_n (rst_n), .cmd (p_cmd), .arg (p_arg),
    .stat (p_stat), .q_rank (p_q_rank), .count (p_count)
  );

  // Table commands for the current step.
  always_comb begin
    t_cmd       = '{act: ACT_NONE, qsel: 1'b0, start: 1'b0, key: key_r,
                    pid: key_r[KEY_W-1 -: PID_W]};
    p_cmd       = t_cmd;
    t_arg       = t_rank_r;
    p_arg       = p_rank_r;
    unique case (state_r)
      ST_T_TOUCH:    t_cmd.act = ACT_TOUCH;
      ST_P_TOUCH:    p_cmd.act = ACT_TOUCH;
      ST_T_TRIM: begin
        t_cmd.qsel = 1'b1;
        t_arg      = TRW'(t_count - TCW'(1));
      end
      ST_T_DROP: begin
        t_cmd.act = ACT_REMOVE;
        t_cmd.key = vkey_r;
      end
      ST_T_INS_GO: begin
        t_cmd.act   = ACT_SCAN_INS;
        t_cmd.start = 1'b1;
      end
      ST_T_INS:      t_cmd.act = ACT_SCAN_INS;
      ST_P_TRIM: begin
        p_cmd.qsel = 1'b1;
        p_arg      = PRW'(p_count - PCW'(1));
      end
      ST_P_DROP: begin
        p_cmd.act = ACT_REMOVE;
        p_cmd.key = vkey_r;
      end
      ST_V_FIND:     t_cmd.key = vkey_r;
      ST_V_DROP: begin
        t_cmd.act = ACT_REMOVE;
        t_cmd.key = vkey_r;
      end
      ST_P_INS_GO: begin
        p_cmd.act   = ACT_SCAN_INS;
        p_cmd.start = 1'b1;
      end
      ST_P_INS:      p_cmd.act = ACT_SCAN_INS;
      ST_FLUSH:      t_cmd.act = ACT_FLUSH;
      ST_T_PURGE_GO: begin
        t_cmd.act   = ACT_SCAN_PURGE;
        t_cmd.start = 1'b1;
      end
      ST_T_PURGE:    t_cmd.act = ACT_SCAN_PURGE;
      ST_P_PURGE_GO: begin
        p_cmd.act   = ACT_SCAN_PURGE;
        p_cmd.start = 1'b1;
      end
      ST_P_PURGE:    p_cmd.act = ACT_SCAN_PURGE;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      page_shift_r   <= 5'd12;
      tlb_limit_r    <= 9'd64;
      tlb_per_proc_r <= 1'b0;
      evict_policy_r <= 1'b0;
      phys_pages_r   <= 11'd1024;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PAGE_SHIFT:   page_shift_r   <= cfg_data[4:0];
          REG_TLB_LIMIT:    tlb_limit_r    <= cfg_data[8:0];
          REG_TLB_PER_PROC: tlb_per_proc_r <= cfg_data[0];
          REG_EVICT_POLICY: evict_policy_r <= cfg_data[0];
          REG_PHYS_PAGES:   phys_pages_r   <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            res_r <= '0;
            key_r <= {in_word.process_id, shifted[PAGE_W-1:0]};
            if (32'(in_word.process_id) >= 32'(MAX_PROCESSES)) state_r <= ST_DONE;
            else if (in_word.op == OP_ACCESS) state_r <= ST_T_FIND;
            else if (in_word.op == OP_SLICE)
              state_r <= tlb_per_proc_r ? ST_FLUSH : ST_DONE;
            else if (in_word.op == OP_END) state_r <= ST_T_PURGE_GO;
            else state_r <= ST_DONE;
          end
        end
        ST_T_FIND: begin
          t_rank_r <= t_q_rank;
          state_r  <= t_stat.q_hit ? ST_T_TOUCH : ST_T_TRIM;
        end
        ST_T_TOUCH: begin
          res_r.tlb_hit <= 1'b1;
          state_r <= evict_policy_r ? ST_P_HFIND : ST_DONE;
        end
        ST_P_HFIND: begin
          p_rank_r <= p_q_rank;
          state_r  <= p_stat.q_hit ? ST_P_TOUCH : ST_DONE;
        end
        ST_P_TOUCH: state_r <= ST_DONE;
        ST_T_TRIM: begin
          t_rank_r <= t_q_rank;
          vkey_r   <= t_stat.q_key;
          if (9'(t_count) >= tl && t_stat.q_hit) state_r <= ST_T_DROP;
          else state_r <= ST_T_INS_GO;
        end
        ST_T_DROP:   state_r <= ST_T_TRIM;
        ST_T_INS_GO: state_r <= ST_T_INS;
        ST_T_INS:    if (t_stat.scan_done) state_r <= ST_P_FIND;
        ST_P_FIND: begin
          p_rank_r <= p_q_rank;
          if (p_stat.q_hit) begin
            state_r <= evict_policy_r ? ST_P_TOUCH : ST_DONE;
          end else begin
            res_r.page_fault <= 1'b1;
            state_r <= ST_P_TRIM;
          end
        end
        ST_P_TRIM: begin
          p_rank_r <= p_q_rank;
          vkey_r   <= p_stat.q_key;
          if (PPW'(p_count) >= pp && p_stat.q_hit) state_r <= ST_P_DROP;
          else state_r <= ST_P_INS_GO;
        end
        ST_P_DROP: begin
          res_r.evicted         <= 1'b1;
          res_r.evicted_process <= vkey_r[KEY_W-1 -: PID_W];
          res_r.evicted_page    <= vkey_r[PAGE_W-1:0];
          state_r <= ST_V_FIND;
        end
        ST_V_FIND: begin
          t_rank_r <= t_q_rank;
          state_r  <= t_stat.q_hit ? ST_V_DROP : ST_P_TRIM;
        end
        ST_V_DROP:     state_r <= ST_P_TRIM;
        ST_P_INS_GO:   state_r <= ST_P_INS;
        ST_P_INS:      if (p_stat.scan_done) state_r <= ST_DONE;
        ST_FLUSH:      state_r <= ST_DONE;
        ST_T_PURGE_GO: state_r <= ST_T_PURGE;
        ST_T_PURGE:    if (t_stat.scan_done) state_r <= ST_P_PURGE_GO;
        ST_P_PURGE_GO: state_r <= ST_P_PURGE;
        ST_P_PURGE: begin
          if (p_stat.act_any) res_r.freed_pages <= res_r.freed_pages + 11'd1;
          if (p_stat.scan_done) state_r <= ST_DONE;
        end
        ST_DONE: begin
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("accepted word did not raise busy");
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result word shown while busy");
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_hit_nofault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_word.tlb_hit && out_word.page_fault))
    else $error("TLB hit reported together with a page fault");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TLB and page frame tracker testbench
// Drives access, slice start and process end words through the command port
// and checks each result word against a typed row or a behavioral model
// of the process-tagged TLB and FIFO/LRU page store, across several settings.
// ----------------------------------------------------------------------------
module tb;
  import tpft_pkg::*;

  localparam int TLB_N  = 256;
  localparam int PAGE_N = 1024;
  localparam int TLB_T  = 0;
  localparam int PAGE_T = 1;
  localparam int N_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 48;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_word_t              in_word = '0;
  logic                  out_valid;
  out_word_t             out_word;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tlb_and_page_frame_tracker_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("tb NOT OK");
    $finish;
  end

  // Model state: index 0 is the TLB, index 1 the page store.
  logic [32:0] tbl_key [2][PAGE_N];
  int          tbl_rank[2][PAGE_N];
  int          tbl_cnt [2];
  int          page_shift_r, tlb_limit_r, per_proc_r, evict_lru_r, phys_pages_r;

  out_word_t   pending_results[$];
  int          failures, n_items, n_hits, n_faults, n_evicts, n_freed;

  function automatic int tbl_depth(int t);
    return (t == TLB_T) ? TLB_N : PAGE_N;
  endfunction

  function automatic int tbl_find(int t, logic [32:0] k);
    for (int i = 0; i < tbl_depth(t); i++)
      if (tbl_key[t][i] == k) return i;
    return -1;
  endfunction

  function automatic void tbl_touch(int t, int s);
    int r;
    r = tbl_rank[t][s];
    for (int i = 0; i < tbl_depth(t); i++)
      if (tbl_key[t][i][32] && tbl_rank[t][i] < r) tbl_rank[t][i]++;
    tbl_rank[t][s] = 0;
  endfunction

  function automatic void tbl_drop(int t, int s);
    int r;
    r = tbl_rank[t][s];
    tbl_key[t][s] = '0;
    tbl_rank[t][s] = 0;
    for (int i = 0; i < tbl_depth(t); i++)
      if (tbl_key[t][i][32] && tbl_rank[t][i] > r) tbl_rank[t][i]--;
    if (tbl_cnt[t] > 0) tbl_cnt[t]--;
  endfunction

  function automatic int tbl_oldest(int t);
    if (tbl_cnt[t] == 0) return -1;
    for (int i = 0; i < tbl_depth(t); i++)
      if (tbl_key[t][i][32] && tbl_rank[t][i] == tbl_cnt[t] - 1) return i;
    return -1;
  endfunction

  function automatic void tbl_add(int t, logic [32:0] k);
    int f;
    f = -1;
    for (int i = 0; i < tbl_depth(t); i++)
      if (!tbl_key[t][i][32]) begin
        f = i;
        break;
      end
    if (f < 0) return;
    for (int i = 0; i < tbl_depth(t); i++)
      if (tbl_key[t][i][32]) tbl_rank[t][i]++;
    tbl_key[t][f] = k;
    tbl_rank[t][f] = 0;
    tbl_cnt[t]++;
  endfunction

  function automatic void tracker_reset();
    for (int t = 0; t < 2; t++) begin
      for (int i = 0; i < PAGE_N; i++) begin
        tbl_key[t][i] = '0;
        tbl_rank[t][i] = 0;
      end
      tbl_cnt[t] = 0;
    end
    page_shift_r = 12;
    tlb_limit_r = 64;
    per_proc_r = 0;
    evict_lru_r = 0;
    phys_pages_r = 1024;
  endfunction

  function automatic int eff_shift();
    return (page_shift_r < 4) ? 4 : (page_shift_r > 16 ? 16 : page_shift_r);
  endfunction

  function automatic out_word_t tracker_step(in_word_t w);
    out_word_t   r;
    int          tl, pp, s, o, v;
    logic [32:0] k, victim;
    logic [27:0] page;
    r = '0;
    if (w.op == OP_SLICE) begin
      if (per_proc_r != 0) begin
        for (int i = 0; i < TLB_N; i++) begin
          tbl_key[TLB_T][i] = '0;
          tbl_rank[TLB_T][i] = 0;
        end
        tbl_cnt[TLB_T] = 0;
      end
    end else if (w.op == OP_END) begin
      for (int i = 0; i < TLB_N; i++)
        if (tbl_key[TLB_T][i][32] && tbl_key[TLB_T][i][31:28] == w.process_id)
          tbl_drop(TLB_T, i);
      for (int i = 0; i < PAGE_N; i++)
        if (tbl_key[PAGE_T][i][32] && tbl_key[PAGE_T][i][31:28] == w.process_id) begin
          tbl_drop(PAGE_T, i);
          r.freed_pages++;
        end
    end else if (w.op == OP_ACCESS) begin
      tl = (tlb_limit_r < 8) ? 8 : (tlb_limit_r > TLB_N ? TLB_N : tlb_limit_r);
      pp = (phys_pages_r < 1) ? 1 : (phys_pages_r > PAGE_N ? PAGE_N : phys_pages_r);
      page = 28'(w.address >> eff_shift());
      k = {1'b1, w.process_id, page};
      s = tbl_find(TLB_T, k);
      if (s >= 0) begin
        tbl_touch(TLB_T, s);
        if (evict_lru_r != 0) begin
          v = tbl_find(PAGE_T, k);
          if (v >= 0) tbl_touch(PAGE_T, v);
        end
        r.tlb_hit = 1'b1;
        return r;
      end
      // A lowered limit can leave the table over-full; drain it first.
      while (tbl_cnt[TLB_T] >= tl) begin
        o = tbl_oldest(TLB_T);
        if (o < 0) break;
        tbl_drop(TLB_T, o);
      end
      tbl_add(TLB_T, k);
      v = tbl_find(PAGE_T, k);
      if (v >= 0) begin
        if (evict_lru_r != 0) tbl_touch(PAGE_T, v);
        return r;
      end
      r.page_fault = 1'b1;
      while (tbl_cnt[PAGE_T] >= pp) begin
        o = tbl_oldest(PAGE_T);
        if (o < 0) break;
        victim = tbl_key[PAGE_T][o];
        tbl_drop(PAGE_T, o);
        s = tbl_find(TLB_T, victim);
        if (s >= 0) tbl_drop(TLB_T, s);
        r.evicted = 1'b1;
        r.evicted_process = victim[31:28];
        r.evicted_page = victim[27:0];
      end
      tbl_add(PAGE_T, k);
    end
    return r;
  endfunction

  // Result checker.
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation pending");
        failures++;
      end else begin
        e = pending_results.pop_front();
        if (out_word.tlb_hit !== e.tlb_hit) begin
          $error("tlb_hit exp %0d got %0d", e.tlb_hit, out_word.tlb_hit);
          failures++;
        end
        if (out_word.page_fault !== e.page_fault) begin
          $error("page_fault exp %0d got %0d", e.page_fault, out_word.page_fault);
          failures++;
        end
        if (out_word.evicted !== e.evicted) begin
          $error("evicted exp %0d got %0d", e.evicted, out_word.evicted);
          failures++;
        end
        if (out_word.evicted_process !== e.evicted_process) begin
          $error("evicted_process exp %0d got %0d", e.evicted_process,
                 out_word.evicted_process);
          failures++;
        end
        if (out_word.evicted_page !== e.evicted_page) begin
          $error("evicted_page exp %h got %h", e.evicted_page, out_word.evicted_page);
          failures++;
        end
        if (out_word.freed_pages !== e.freed_pages) begin
          $error("freed_pages exp %0d got %0d", e.freed_pages, out_word.freed_pages);
          failures++;
        end
        n_hits += e.tlb_hit;
        n_faults += e.page_fault;
        n_evicts += e.evicted;
        if (e.freed_pages != 0) n_freed++;
      end
    end
  end

  int burst_left;

  // Holds start high until the word is taken, then keeps it up within a burst
  // or drops it for a random gap.
  task automatic send_word(in_word_t w, bit typed, out_word_t typed_res);
    out_word_t p;
    int        gap;
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = tracker_step(w);
    pending_results.push_back(typed ? typed_res : p);
    n_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 10);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PAGE_SHIFT:   page_shift_r = val & 32'h1f;
      REG_TLB_LIMIT:    tlb_limit_r = val & 32'h1ff;
      REG_TLB_PER_PROC: per_proc_r = val & 1;
      REG_EVICT_POLICY: evict_lru_r = val & 1;
      REG_PHYS_PAGES:   phys_pages_r = val & 32'h7ff;
      default: ;
    endcase
  endtask

  function automatic out_word_t res(bit hit, bit fault, int freed);
    out_word_t r;
    r = '0;
    r.tlb_hit = hit;
    r.page_fault = fault;
    r.freed_pages = 11'(freed);
    return r;
  endfunction

  typedef struct {
    logic [1:0]  op;
    logic [3:0]  pid;
    logic [31:0] addr;
    out_word_t   res;
  } dir_row_t;

  // Settings per phase: shift, TLB limit, per-process, LRU, frames.
  int phase_cfg[N_PHASES][5] = '{
    '{4, 8, 0, 0, 1},
    '{16, 256, 1, 1, 1024},
    '{0, 0, 1, 1, 0},
    '{31, 511, 0, 1, 2047},
    '{5, 12, 1, 0, 20},
    '{8, 30, 0, 1, 50},
    '{6, 9, 1, 1, 8},
    '{4, 16, 0, 0, 12}
  };

  initial begin
    dir_row_t  rows[$];
    in_word_t  w;
    int        pg_span, sh;
    failures = 0;
    n_items = 0;
    n_hits = 0;
    n_faults = 0;
    n_evicts = 0;
    n_freed = 0;
    burst_left = 0;
    tracker_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: 4 KiB pages, 64 TLB entries, 1024 frames, global TLB.
    rows = '{
      '{OP_ACCESS, 4'd0,  32'h0000_0000, res(0, 1, 0)},
      '{OP_ACCESS, 4'd0,  32'h0000_0fff, res(1, 0, 0)},
      '{OP_ACCESS, 4'd15, 32'hffff_ffff, res(0, 1, 0)},
      '{OP_ACCESS, 4'd15, 32'hffff_f000, res(1, 0, 0)},
      '{2'd3,      4'd7,  32'h5555_5555, res(0, 0, 0)},
      '{OP_SLICE,  4'd3,  32'h0000_0000, res(0, 0, 0)},
      '{OP_END,    4'd0,  32'h0000_0000, res(0, 0, 1)},
      '{OP_ACCESS, 4'd0,  32'h0000_0000, res(0, 1, 0)},
      '{OP_END,    4'd9,  32'hffff_ffff, res(0, 0, 0)},
      '{OP_ACCESS, 4'd5,  32'haaaa_aaaa, res(0, 1, 0)},
      '{OP_ACCESS, 4'd5,  32'h1234_5678, res(0, 1, 0)},
      '{OP_ACCESS, 4'd5,  32'h1234_5abc, res(1, 0, 0)},
      '{OP_ACCESS, 4'd10, 32'h0000_1000, res(0, 1, 0)},
      '{OP_END,    4'd5,  32'h0000_0000, res(0, 0, 2)},
      '{OP_ACCESS, 4'd10, 32'h0000_1fff, res(1, 0, 0)}
    };
    foreach (rows[i]) begin
      w.op = rows[i].op;
      w.process_id = rows[i].pid;
      w.address = rows[i].addr;
      send_word(w, 1'b1, rows[i].res);
    end
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_reg(REG_PAGE_SHIFT, phase_cfg[ph][0]);
      write_reg(REG_TLB_LIMIT, phase_cfg[ph][1]);
      write_reg(REG_TLB_PER_PROC, phase_cfg[ph][2]);
      write_reg(REG_EVICT_POLICY, phase_cfg[ph][3]);
      write_reg(REG_PHYS_PAGES, phase_cfg[ph][4]);
      cfg_valid <= 1'b0;
      sh = eff_shift();
      pg_span = (phys_pages_r < 64) ? phys_pages_r + 8 : 40;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        int roll;
        roll = $urandom_range(0, 99);
        w.op = (roll < 82) ? OP_ACCESS : (roll < 90) ? OP_SLICE : (roll < 97) ? OP_END : 2'd3;
        w.process_id = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0)
          w.address = $urandom;
        else
          w.address = (32'($urandom_range(0, pg_span)) << sh)
                    | ($urandom & ((32'd1 << sh) - 1));
        send_word(w, 1'b0, '0);
      end
      drain();
    end

    $display("Ran %0d words over %0d register settings: %0d TLB hits, %0d faults,",
             n_items, N_PHASES + 1, n_hits, n_faults);
    $display("%0d page-outs and %0d process ends that freed frames.", n_evicts, n_freed);
    if (failures == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
